@@ sv/ckerng_pkg.sv @@
// Package for the key-erasure random generator: constants, types and round helpers.
`default_nettype none
package ckerng_pkg;

  localparam int unsigned REKEY_WORDS   = 262144;
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned QR_STEPS      = 8 * DOUBLE_ROUNDS;
  localparam int unsigned STEP_W        = $clog2(QR_STEPS);
  localparam int unsigned WSR_W         = 19;

  localparam logic [1:0] KIND_SEED    = 2'd0;
  localparam logic [1:0] KIND_ENTROPY = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;

  localparam logic [1:0] STATUS_WORD    = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  localparam logic [3:0] SLOT_LAST_KEY = 4'd7;
  localparam logic [3:0] SLOT_LAST     = 4'd10;

  localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                        32'h79622d32, 32'h6b206574};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL
  } state_t;

  typedef logic [3:0][31:0] qr_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // One quarter round; element 0 is a, 3 is d.
  function automatic qr_t quarter(input logic [31:0] a_in, input logic [31:0] b_in,
                                  input logic [31:0] c_in, input logic [31:0] d_in);
    logic [31:0] a, b, c, d;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    quarter = {d, c, b, a};
  endfunction

endpackage
`default_nettype wire

@@ sv/chacha20_key_erasure_rng.sv @@
// Top level: ChaCha20 random word generator with fast key erasure.
//
// Input channel (in_valid/in_ready) takes seed words, entropy bytes and
// word requests; every transfer yields exactly one result on the output
// channel (out_valid/out_ready) carrying out_random_word and out_status.
// One item is worked on at a time: in_ready is low while a block is being
// computed and while a result waits to be taken.
// Seed, non-final entropy, refused and ignored items, and requests served
// from a buffer that still holds words, produce their result in the cycle
// after the transfer. A block computation runs one shared quarter-round
// unit over the state: a load state, QR_STEPS quarter-round steps and a
// feed-forward state. A request that finds the buffer empty costs one
// block; a due rekey adds another block. Sixteen words come from each
// block. A final entropy byte triggers a rekey before its result.
// Synchronous reset (rst_n low) drops any result, marks the block unseeded
// and empties the buffer. A stalled receiver holds the result steady and
// keeps in_ready low until the transfer.
`default_nettype none
module chacha20_key_erasure_rng (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [3:0]  in_word_index,
  input  wire logic [31:0] in_seed_word,
  input  wire logic [7:0]  in_entropy_byte,
  input  wire logic [2:0]  in_byte_position,
  input  wire logic        in_last_entropy,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_word,
  output logic [1:0]       out_status
);

  localparam int unsigned SW = ckerng_pkg::STEP_W;
  localparam int unsigned WW = ckerng_pkg::WSR_W;

  ckerng_pkg::state_t state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          rekey_mode_r, rekey_mode_nxt;
  logic          pend_req_r, pend_req_nxt;
  logic          seeded_r, seeded_nxt;
  logic [4:0]    pos_r, pos_nxt;
  logic [WW-1:0] wsr_r, wsr_nxt;
  logic [31:0]   ctr_r, ctr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [1:0]    status_r, status_nxt;

  logic [31:0] key_r [8];
  logic [31:0] key_nxt [8];
  logic [31:0] nonce_r [3];
  logic [31:0] nonce_nxt [3];
  logic [31:0] buf_r [16];
  logic [31:0] buf_nxt [16];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];

  logic [31:0] init_w [16];
  logic [31:0] sum_w [16];
  logic [31:0] qr_w [16];
  logic [31:0] col_w [16];
  logic [31:0] perm_w [16];
  ckerng_pkg::qr_t qr_out;
  logic        accept;
  logic [31:0] mix_word;

  assign in_ready        = (state_r == ckerng_pkg::ST_IDLE) && !out_valid_r;
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = word_r;
  assign out_status      = status_r;
  assign mix_word        = 32'(in_entropy_byte) << {in_byte_position[1:0], 3'b000};

  // Block input words and feed-forward sums.
  always_comb begin
    for (int i = 0; i < 4; i++) init_w[i] = ckerng_pkg::SIGMA[i];
    for (int i = 0; i < 8; i++) init_w[4 + i] = key_r[i];
    init_w[12] = ctr_r;
    for (int i = 0; i < 3; i++) init_w[13 + i] = nonce_r[i];
    for (int i = 0; i < 16; i++) sum_w[i] = w_r[i] + init_w[i];
  end

  // Quarter round on column 0, then shift columns left; diagonalise after
  // the fourth step and undo it after the eighth.
  always_comb begin
    qr_out = ckerng_pkg::quarter(w_r[0], w_r[4], w_r[8], w_r[12]);
    for (int i = 0; i < 16; i++) qr_w[i] = w_r[i];
    qr_w[0]  = qr_out[0];
    qr_w[4]  = qr_out[1];
    qr_w[8]  = qr_out[2];
    qr_w[12] = qr_out[3];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) col_w[4 * r + c] = qr_w[4 * r + ((c + 1) % 4)];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (step_r[2:0] == 3'd3) perm_w[4 * r + c] = col_w[4 * r + ((c + r) % 4)];
        else if (step_r[2:0] == 3'd7) perm_w[4 * r + c] = col_w[4 * r + ((c + 4 - r) % 4)];
        else perm_w[4 * r + c] = col_w[4 * r + c];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    rekey_mode_nxt = rekey_mode_r;
    pend_req_nxt   = pend_req_r;
    seeded_nxt     = seeded_r;
    pos_nxt        = pos_r;
    wsr_nxt        = wsr_r;
    ctr_nxt        = ctr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    word_nxt       = word_r;
    status_nxt     = status_r;
    key_nxt        = key_r;
    nonce_nxt      = nonce_r;
    buf_nxt        = buf_r;
    w_nxt          = w_r;

    unique case (state_r)
      ckerng_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          word_nxt      = '0;
          status_nxt    = ckerng_pkg::STATUS_DONE;
          priority if (in_kind == ckerng_pkg::KIND_SEED) begin
            if (in_word_index <= ckerng_pkg::SLOT_LAST_KEY) begin
              key_nxt[in_word_index[2:0]] = in_seed_word;
            end else if (in_word_index <= ckerng_pkg::SLOT_LAST) begin
              nonce_nxt[2'(in_word_index - 4'd8)] = in_seed_word;
              if (in_word_index == ckerng_pkg::SLOT_LAST) begin
                ctr_nxt    = '0;
                pos_nxt    = 5'd16;
                wsr_nxt    = '0;
                seeded_nxt = 1'b1;
              end
            end
          end else if (in_kind == ckerng_pkg::KIND_ENTROPY) begin
            if (!seeded_r) begin
              status_nxt = ckerng_pkg::STATUS_REFUSED;
            end else begin
              key_nxt[in_byte_position] = key_r[in_byte_position] ^ mix_word;
              if (in_last_entropy) begin
                out_valid_nxt  = 1'b0;
                rekey_mode_nxt = 1'b1;
                pend_req_nxt   = 1'b0;
                state_nxt      = ckerng_pkg::ST_LOAD;
              end
            end
          end else if (in_kind == ckerng_pkg::KIND_REQUEST) begin
            if (!seeded_r) begin
              status_nxt = ckerng_pkg::STATUS_REFUSED;
            end else if (wsr_r >= WW'(ckerng_pkg::REKEY_WORDS) || pos_r[4]) begin
              out_valid_nxt  = 1'b0;
              rekey_mode_nxt = (wsr_r >= WW'(ckerng_pkg::REKEY_WORDS));
              pend_req_nxt   = 1'b1;
              state_nxt      = ckerng_pkg::ST_LOAD;
            end else begin
              word_nxt   = buf_r[pos_r[3:0]];
              status_nxt = ckerng_pkg::STATUS_WORD;
              pos_nxt    = pos_r + 5'd1;
              wsr_nxt    = wsr_r + WW'(1);
            end
          end else begin
            status_nxt = ckerng_pkg::STATUS_DONE;
          end
        end
      end
      ckerng_pkg::ST_LOAD: begin
        w_nxt     = init_w;
        step_nxt  = '0;
        state_nxt = ckerng_pkg::ST_ROUND;
      end
      ckerng_pkg::ST_ROUND: begin
        w_nxt    = perm_w;
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(ckerng_pkg::QR_STEPS - 1)) state_nxt = ckerng_pkg::ST_FINAL;
      end
      ckerng_pkg::ST_FINAL: begin
        if (rekey_mode_r) begin
          // Adopt the block as new key and nonce; drop the rest.
          for (int i = 0; i < 8; i++) key_nxt[i] = sum_w[i];
          for (int i = 0; i < 3; i++) nonce_nxt[i] = sum_w[8 + i];
          ctr_nxt        = '0;
          pos_nxt        = 5'd16;
          wsr_nxt        = '0;
          rekey_mode_nxt = 1'b0;
          if (pend_req_r) begin
            state_nxt = ckerng_pkg::ST_LOAD;
          end else begin
            out_valid_nxt = 1'b1;
            word_nxt      = '0;
            status_nxt    = ckerng_pkg::STATUS_DONE;
            state_nxt     = ckerng_pkg::ST_IDLE;
          end
        end else begin
          buf_nxt       = sum_w;
          ctr_nxt       = ctr_r + 32'd1;
          pos_nxt       = 5'd1;
          wsr_nxt       = wsr_r + WW'(1);
          pend_req_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          word_nxt      = sum_w[0];
          status_nxt    = ckerng_pkg::STATUS_WORD;
          state_nxt     = ckerng_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ckerng_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ckerng_pkg::ST_IDLE;
      step_r       <= '0;
      rekey_mode_r <= 1'b0;
      pend_req_r   <= 1'b0;
      seeded_r     <= 1'b0;
      pos_r        <= 5'd16;
      wsr_r        <= '0;
      ctr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      rekey_mode_r <= rekey_mode_nxt;
      pend_req_r   <= pend_req_nxt;
      seeded_r     <= seeded_nxt;
      pos_r        <= pos_nxt;
      wsr_r        <= wsr_nxt;
      ctr_r        <= ctr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    status_r <= status_nxt;
    key_r    <= key_nxt;
    nonce_r  <= nonce_nxt;
    buf_r    <= buf_nxt;
    w_r      <= w_nxt;
  end

endmodule
`default_nettype wire

@@ sv/chacha20_key_erasure_rng_checker.sv @@
// Port-level checker for the key-erasure random generator, bound to the top level.
`default_nettype none
module chacha20_key_erasure_rng_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_random_word,
  input wire logic [1:0]  out_status
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word) && $stable(out_status))
    else $error("result changed while stalled");

  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ckerng_pkg::STATUS_WORD |-> out_random_word == 32'd0)
    else $error("word not zero without delivery");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ckerng_pkg::STATUS_WORD ||
                  out_status == ckerng_pkg::STATUS_DONE ||
                  out_status == ckerng_pkg::STATUS_REFUSED)
    else $error("unknown status code");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again straight after a transfer");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind chacha20_key_erasure_rng chacha20_key_erasure_rng_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_random_word(out_random_word), .out_status(out_status)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the ChaCha20 key-erasure random word generator.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int N_RANDOM       = 1700;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  word_index;
    logic [31:0] seed_word;
    logic [7:0]  entropy_byte;
    logic [2:0]  byte_position;
    logic        last_entropy;
    bit          drain_first;
  } gen_item_t;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  status;
  } gen_result_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_kind;
  logic [3:0]  in_word_index;
  logic [31:0] in_seed_word;
  logic [7:0]  in_entropy_byte;
  logic [2:0]  in_byte_position;
  logic        in_last_entropy;
  logic        out_valid, out_ready;
  logic [31:0] out_random_word;
  logic [1:0]  out_status;

  chacha20_key_erasure_rng dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_word_index(in_word_index),
    .in_seed_word(in_seed_word), .in_entropy_byte(in_entropy_byte),
    .in_byte_position(in_byte_position), .in_last_entropy(in_last_entropy),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_random_word(out_random_word), .out_status(out_status)
  );

  // Predictor state
  logic [31:0] m_key [8];
  logic [31:0] m_nonce [3];
  logic [31:0] m_counter;
  logic [31:0] m_buf [16];
  logic [4:0]  m_pos;
  logic [18:0] m_since_rekey;
  logic        m_seeded;
  logic [31:0] blk [16];

  gen_item_t   pending_items [$];
  gen_result_t expected_results [$];

  int mismatches, watchdog, gap_left, ostall;
  int n_words, n_entropy, n_rekeys, n_seeds, n_refused;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

  function void qround(input int a, input int b, input int c, input int d);
    blk[a] = blk[a] + blk[b]; blk[d] = rotl32(blk[d] ^ blk[a], 16);
    blk[c] = blk[c] + blk[d]; blk[b] = rotl32(blk[b] ^ blk[c], 12);
    blk[a] = blk[a] + blk[b]; blk[d] = rotl32(blk[d] ^ blk[a], 8);
    blk[c] = blk[c] + blk[d]; blk[b] = rotl32(blk[b] ^ blk[c], 7);
  endfunction

  function void compute_block();
    logic [31:0] init [16];
    int i;
    init[0] = 32'h61707865; init[1] = 32'h3320646e;
    init[2] = 32'h79622d32; init[3] = 32'h6b206574;
    for (i = 0; i < 8; i++) init[4 + i] = m_key[i];
    init[12] = m_counter;
    for (i = 0; i < 3; i++) init[13 + i] = m_nonce[i];
    for (i = 0; i < 16; i++) blk[i] = init[i];
    for (i = 0; i < ckerng_pkg::DOUBLE_ROUNDS; i++) begin
      qround(0, 4, 8, 12); qround(1, 5, 9, 13);
      qround(2, 6, 10, 14); qround(3, 7, 11, 15);
      qround(0, 5, 10, 15); qround(1, 6, 11, 12);
      qround(2, 7, 8, 13); qround(3, 4, 9, 14);
    end
    for (i = 0; i < 16; i++) m_buf[i] = blk[i] + init[i];
    m_counter = m_counter + 32'd1;
    m_pos = 5'd0;
  endfunction

  // Adopt a fresh block as key and nonce, then erase those words
  function void erase_rekey();
    int i;
    compute_block();
    for (i = 0; i < 8; i++) m_key[i] = m_buf[i];
    for (i = 0; i < 3; i++) m_nonce[i] = m_buf[8 + i];
    for (i = 0; i < 12; i++) m_buf[i] = 32'd0;
    m_counter = 32'd0;
    m_pos = 5'd16;
    m_since_rekey = 19'd0;
    n_rekeys++;
  endfunction

  function automatic gen_result_t step_generator(input gen_item_t it);
    gen_result_t r;
    r.word = 32'd0;
    r.status = ckerng_pkg::STATUS_DONE;
    case (it.kind)
      ckerng_pkg::KIND_SEED: begin
        if (it.word_index <= ckerng_pkg::SLOT_LAST_KEY) m_key[it.word_index[2:0]] = it.seed_word;
        else if (it.word_index <= ckerng_pkg::SLOT_LAST) begin
          m_nonce[2'(it.word_index - 4'd8)] = it.seed_word;
          if (it.word_index == ckerng_pkg::SLOT_LAST) begin
            m_counter = 32'd0; m_pos = 5'd16; m_since_rekey = 19'd0; m_seeded = 1'b1;
            n_seeds++;
          end
        end
      end
      ckerng_pkg::KIND_ENTROPY: begin
        if (!m_seeded) r.status = ckerng_pkg::STATUS_REFUSED;
        else begin
          m_key[it.byte_position] = m_key[it.byte_position] ^
            (32'(it.entropy_byte) << (8 * it.byte_position[1:0]));
          n_entropy++;
          if (it.last_entropy) erase_rekey();
        end
      end
      ckerng_pkg::KIND_REQUEST: begin
        if (!m_seeded) r.status = ckerng_pkg::STATUS_REFUSED;
        else begin
          if (m_since_rekey >= ckerng_pkg::REKEY_WORDS) erase_rekey();
          if (m_pos >= 5'd16) compute_block();
          r.word = m_buf[m_pos[3:0]];
          m_pos = m_pos + 5'd1;
          m_since_rekey = m_since_rekey + 19'd1;
          r.status = ckerng_pkg::STATUS_WORD;
          n_words++;
        end
      end
      default: ;
    endcase
    if (r.status == ckerng_pkg::STATUS_REFUSED) n_refused++;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic gen_item_t noise_item();
    gen_item_t it;
    it.kind = 2'($urandom_range(0, 3));
    it.word_index = 4'($urandom_range(0, 15));
    it.seed_word = $urandom;
    it.entropy_byte = 8'($urandom_range(0, 255));
    it.byte_position = 3'($urandom_range(0, 7));
    it.last_entropy = 1'($urandom_range(0, 1));
    it.drain_first = 0;
    return it;
  endfunction

  task automatic push_kind(input logic [1:0] k, input logic [3:0] slot, input logic last);
    gen_item_t it;
    it = noise_item();
    it.kind = k;
    it.word_index = slot;
    it.last_entropy = last;
    pending_items.push_back(it);
  endtask

  task automatic push_seed_set();
    int s;
    for (s = 0; s <= 10; s++) push_kind(ckerng_pkg::KIND_SEED, 4'(s), 1'b0);
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Driver: hold each item until its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(step_generator(
        '{in_kind, in_word_index, in_seed_word, in_entropy_byte,
          in_byte_position, in_last_entropy, 1'b0}));
      if (in_valid && !in_ready) begin
        // hold
      end else if (gap_left > 0) begin
        in_valid <= 0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain_first && expected_results.size() != 0)) begin
        in_valid <= 0;
      end else begin
        gen_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1;
        in_kind <= it.kind;
        in_word_index <= it.word_index;
        in_seed_word <= it.seed_word;
        in_entropy_byte <= it.entropy_byte;
        in_byte_position <= it.byte_position;
        in_last_entropy <= it.last_entropy;
        gap_left <= pick_gap();
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      ostall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: word %h status %0d", out_random_word, out_status);
        end else begin
          gen_result_t e;
          e = expected_results.pop_front();
          if (e.word !== out_random_word || e.status !== out_status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected word %h status %0d, got word %h status %0d",
                       e.word, e.status, out_random_word, out_status);
          end
        end
      end
      if (ostall > 0) begin
        out_ready <= 0;
        ostall <= ostall - 1;
      end else begin
        out_ready <= 1;
        if (out_valid && out_ready) ostall <= pick_gap();
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int i, r, p;
    rst_n = 0; in_valid = 0; out_ready = 0;
    in_kind = 0; in_word_index = 0; in_seed_word = 0;
    in_entropy_byte = 0; in_byte_position = 0; in_last_entropy = 0;
    mismatches = 0; watchdog = 0; gap_left = 0; ostall = 0;
    n_words = 0; n_entropy = 0; n_rekeys = 0; n_seeds = 0; n_refused = 0;
    for (i = 0; i < 8; i++) m_key[i] = 0;
    for (i = 0; i < 3; i++) m_nonce[i] = 0;
    for (i = 0; i < 16; i++) m_buf[i] = 0;
    m_counter = 0; m_pos = 16; m_since_rekey = 0; m_seeded = 0;

    // Directed: refusals before seeding, ignored kind and slots, seeding, rekey
    push_kind(ckerng_pkg::KIND_ENTROPY, 4'd0, 1'b1);
    push_kind(ckerng_pkg::KIND_REQUEST, 4'd0, 1'b0);
    push_kind(2'd3, 4'd0, 1'b0);
    push_kind(ckerng_pkg::KIND_SEED, 4'd15, 1'b0);
    push_kind(ckerng_pkg::KIND_SEED, 4'd11, 1'b0);
    for (i = 0; i <= 10; i++) begin
      push_kind(ckerng_pkg::KIND_SEED, 4'(i), 1'b0);
      pending_items[$].seed_word = (i % 2) ? 32'hFFFFFFFF : 32'h0;
    end
    for (i = 0; i < 3; i++) push_kind(ckerng_pkg::KIND_REQUEST, 4'd0, 1'b0);
    push_kind(ckerng_pkg::KIND_ENTROPY, 4'd0, 1'b0);
    pending_items[$].entropy_byte = 8'hFF; pending_items[$].byte_position = 3'd7;
    push_kind(ckerng_pkg::KIND_ENTROPY, 4'd0, 1'b1);
    pending_items[$].entropy_byte = 8'h00; pending_items[$].byte_position = 3'd0;
    push_kind(ckerng_pkg::KIND_REQUEST, 4'd0, 1'b0);
    pending_items[$].drain_first = 1;

    // Random: mostly requests and entropy, with reseeds and noise
    i = 0;
    while (i < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        p = $urandom_range(1, 20);
        repeat (p) push_kind(ckerng_pkg::KIND_REQUEST, 4'd0, 1'b0);
        i += p;
      end else if (r < 85) begin
        push_kind(ckerng_pkg::KIND_ENTROPY, 4'd0, ($urandom_range(0, 7) == 0));
        i++;
      end else if (r < 89) begin
        push_seed_set();
        i += 11;
      end else begin
        pending_items.push_back(noise_item());
        i++;
      end
      if ($urandom_range(0, 99) == 0) pending_items[$].drain_first = 1;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1;

    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d words, %0d entropy bytes, %0d rekeys, %0d seedings",
             n_words, n_entropy, n_rekeys, n_seeds);
    $display("refused before seeding: %0d, mismatches: %0d", n_refused, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
